FILE: hw/rtl/deque_with_linear_search_macros.svh
// assertion macros for the deque with linear search
// used by the checker; expects clk_i and rst_ni in scope
`ifndef DEQUE_WITH_LINEAR_SEARCH_MACROS_SVH
`define DEQUE_WITH_LINEAR_SEARCH_MACROS_SVH

// plain clocked property, masked while reset is asserted
`define DQLS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// a stalled request keeps valid high and its payload unchanged
`define DQLS_HOLD(label, vld, rdy, sig, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && !rdy) |=> (vld && $stable(sig))) else $error(msg);

`endif

FILE: hw/rtl/dqls_pkg.sv
// shared types and constants for the deque with linear search
// no dependencies; imported by every rtl module of the block
package dqls_pkg;

  localparam int unsigned DqlsDepth     = 64;
  localparam int unsigned DqlsDataWidth = 32;
  localparam int unsigned ValueWidth    = 32;
  localparam int unsigned PosWidth      = 6;

  typedef enum logic [1:0] {
    MODE_PUSH_FRONT   = 2'd0,
    MODE_PUSH_REAR    = 2'd1,
    MODE_SEARCH_FRONT = 2'd2,
    MODE_SEARCH_REAR  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_PUSHED    = 3'd0,
    ST_FULL      = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef struct packed {
    mode_e                        mode;
    logic signed [ValueWidth-1:0] value;
  } in_req_t;

  typedef struct packed {
    status_e             status;
    logic [PosWidth-1:0] position;
  } out_rsp_t;

  // controller to datapath
  typedef struct packed {
    logic    latch;
    logic    push;
    logic    search_start;
    logic    search_step;
    logic    res_we;
    status_e res_status;
    logic    out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_push;
    logic full;
    logic empty;
    logic match;
    logic last;
  } stat_t;

endpackage

FILE: hw/rtl/deque_with_linear_search.sv
// deque with linear search: push front or rear, search from either end
// a push, a full list and an empty list are resolved in the exec state; a search reads
// one entry per cycle from the ring store until a match or the last entry
// the next request is taken once the result is loaded into the output register
// reset (async, active low) empties the list; store contents are not cleared
module deque_with_linear_search #(
  parameter int unsigned DEPTH      = dqls_pkg::DqlsDepth,
  parameter int unsigned DATA_WIDTH = dqls_pkg::DqlsDataWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dqls_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dqls_pkg::out_rsp_t out_rsp_o
);
  import dqls_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  dqls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dqls_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_req_i  (in_req_i),
    .stat_o    (stat),
    .out_rsp_o (out_rsp_o)
  );

endmodule

FILE: hw/rtl/dqls_datapath.sv
// datapath: ring store, head and count registers, search pipeline, result registers
// depends on dqls_pkg
module dqls_datapath #(
  parameter int unsigned DEPTH      = dqls_pkg::DqlsDepth,
  parameter int unsigned DATA_WIDTH = dqls_pkg::DqlsDataWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dqls_pkg::cmd_t     cmd_i,
  input  dqls_pkg::in_req_t  in_req_i,
  output dqls_pkg::stat_t    stat_o,
  output dqls_pkg::out_rsp_t out_rsp_o
);
  import dqls_pkg::*;

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned AW1  = AW + 1;
  localparam int unsigned PW   = AW + PosWidth;
  localparam logic [AW-1:0] LastIdx  = AW'(DEPTH - 1);
  localparam logic [AW:0]   DepthW   = AW1'(DEPTH);
  localparam logic [CW-1:0] DepthCnt = CW'(DEPTH);

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];

  logic [AW-1:0]         head_q, head_d;
  logic [CW-1:0]         count_q, count_d;
  logic [AW-1:0]         rd_i_q, rd_i_d;
  logic                  cmp_valid_q, cmp_valid_d;
  logic [AW-1:0]         cmp_i_q;
  logic [DATA_WIDTH-1:0] rd_data_q;
  mode_e                 mode_q;
  logic [DATA_WIDTH-1:0] val_q;
  out_rsp_t              res_q, rsp_q;

  logic [63:0]           val_ext;
  logic [CW-1:0]         cnt_m1;
  logic [AW-1:0]         last_pos;
  logic [AW-1:0]         front_addr, rear_addr, wr_addr;
  logic [AW-1:0]         logical, rd_addr;
  logic [PW-1:0]         pos_ext;

  // head plus offset, wrapped once around the ring
  function automatic logic [AW-1:0] ring_idx(logic [AW-1:0] base, logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DepthW) sum = sum - DepthW;
    return sum[AW-1:0];
  endfunction

  assign val_ext    = 64'($signed(in_req_i.value));
  assign cnt_m1     = count_q - CW'(1);
  assign last_pos   = cnt_m1[AW-1:0];
  assign front_addr = (head_q == '0) ? LastIdx : head_q - AW'(1);
  assign rear_addr  = ring_idx(head_q, count_q[AW-1:0]);
  assign wr_addr    = (mode_q == MODE_PUSH_FRONT) ? front_addr : rear_addr;
  assign logical    = (mode_q == MODE_SEARCH_FRONT) ? rd_i_q : last_pos - rd_i_q;
  assign rd_addr    = ring_idx(head_q, logical);
  assign pos_ext    = PW'(cmp_i_q);

  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    rd_i_d      = rd_i_q;
    cmp_valid_d = cmp_valid_q;
    if (cmd_i.push) begin
      if (mode_q == MODE_PUSH_FRONT) head_d = front_addr;
      count_d = count_q + CW'(1);
    end
    if (cmd_i.search_start) begin
      rd_i_d      = '0;
      cmp_valid_d = 1'b0;
    end
    if (cmd_i.search_step) begin
      rd_i_d      = rd_i_q + AW'(1);
      cmp_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      rd_i_q      <= '0;
      cmp_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      count_q     <= count_d;
      rd_i_q      <= rd_i_d;
      cmp_valid_q <= cmp_valid_d;
    end
  end

  // ring store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) mem_q[wr_addr] <= val_q;
    if (cmd_i.search_step) begin
      rd_data_q <= mem_q[rd_addr];
      cmp_i_q   <= rd_i_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q <= in_req_i.mode;
      val_q  <= val_ext[DATA_WIDTH-1:0];
    end
    if (cmd_i.res_we) begin
      res_q.status   <= cmd_i.res_status;
      res_q.position <= (cmd_i.res_status == ST_FOUND) ? pos_ext[PosWidth-1:0] : '0;
    end
    if (cmd_i.out_load) rsp_q <= res_q;
  end

  assign stat_o.is_push = (mode_q == MODE_PUSH_FRONT) || (mode_q == MODE_PUSH_REAR);
  assign stat_o.full    = (count_q == DepthCnt);
  assign stat_o.empty   = (count_q == '0);
  assign stat_o.match   = cmp_valid_q && (rd_data_q == val_q);
  assign stat_o.last    = cmp_valid_q && (cmp_i_q == last_pos);

  assign out_rsp_o = rsp_q;

endmodule

FILE: hw/rtl/dqls_ctrl.sv
// controller: sequences accept, push or search, and result hand-off
// depends on dqls_pkg
module dqls_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  dqls_pkg::stat_t stat_i,
  output dqls_pkg::cmd_t  cmd_o
);
  import dqls_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    cmd_o.res_status = ST_PUSHED;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.is_push) begin
          cmd_o.res_we = 1'b1;
          if (stat_i.full) begin
            cmd_o.res_status = ST_FULL;
          end else begin
            cmd_o.push       = 1'b1;
            cmd_o.res_status = ST_PUSHED;
          end
          state_d = S_DONE;
        end else if (stat_i.empty) begin
          cmd_o.res_we     = 1'b1;
          cmd_o.res_status = ST_EMPTY;
          state_d          = S_DONE;
        end else begin
          cmd_o.search_start = 1'b1;
          state_d            = S_SEARCH;
        end
      end
      S_SEARCH: begin
        // read of the next entry overlaps the compare of the previous one
        cmd_o.search_step = 1'b1;
        if (stat_i.match) begin
          cmd_o.res_we     = 1'b1;
          cmd_o.res_status = ST_FOUND;
          state_d          = S_DONE;
        end else if (stat_i.last) begin
          cmd_o.res_we     = 1'b1;
          cmd_o.res_status = ST_NOT_FOUND;
          state_d          = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: hw/rtl/dqls_checker.sv
// port-level checker for the deque with linear search, bound to the top level
// depends on dqls_pkg and deque_with_linear_search_macros.svh
`include "deque_with_linear_search_macros.svh"

module dqls_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input dqls_pkg::in_req_t  in_req_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input dqls_pkg::out_rsp_t out_rsp_o
);
  import dqls_pkg::*;

  `DQLS_HOLD(a_in_hold, in_valid_i, in_ready_o, in_req_i, "request changed while stalled")

  `DQLS_HOLD(a_out_hold, out_valid_o, out_ready_i, out_rsp_o, "result changed while stalled")

  `DQLS_ASSERT(a_pos_zero, (out_valid_o && (out_rsp_o.status != ST_FOUND)) |-> (out_rsp_o.position == '0), "nonzero position without a match")

  `DQLS_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o, "request taken while busy")

  `DQLS_ASSERT(a_no_early_result, (in_valid_i && in_ready_o) |=> !$rose(out_valid_o), "result before request was processed")

endmodule

bind deque_with_linear_search dqls_checker u_dqls_checker (.*);
